// ===== rtl/arcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcr_pkg
// Shared types and constants of the adaptive replacement cache directory.
// ----------------------------------------------------------------------------
package arcr_pkg;

    localparam int KEY_W = 31;
    localparam int CFG_W = 7;
    localparam int HIT_W = 32;
    localparam int OUT_W = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        LIST_T1,
        LIST_T2,
        LIST_B1,
        LIST_B2
    } t_list;

    typedef enum logic [1:0] {
        OUT_MISS,
        OUT_HIT,
        OUT_GHOST_B1,
        OUT_GHOST_B2
    } t_outcome;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_DROP,
        OP_MOVE,
        OP_INSERT
    } t_op_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_ADAPT,
        S_DIV,
        S_PLAN,
        S_EDIT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/arc_cache_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_cache_replacement_core
// Adaptive replacement cache directory: one page request in, one outcome out.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------
//  request   | in        | i_in_valid / o_in_stall   | i_page_key[30:0]
//  result    | out       | o_out_valid / i_out_stall | o_outcome[1:0], o_hit_total
//  config    | in        | i_cfg_we                  | i_cfg_data[6:0] (cache_size)
//
//  After reset a clearing pass over all 2*CAPACITY entries empties the
//  directory; requests are stalled meanwhile. Each request then takes one
//  lookup sweep over the directory memory, a divide on a ghost hit, and one
//  edit sweep per list change (up to three). The memory port sets the pace.
//  A waiting result does not block the next request from being taken, only
//  from being finished.
// ----------------------------------------------------------------------------
module arc_cache_replacement_core #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [arcr_pkg::KEY_W-1:0]    i_page_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [arcr_pkg::OUT_W-1:0]    o_outcome,
    output logic [arcr_pkg::HIT_W-1:0]    o_hit_total,
    input  logic                          i_cfg_we,
    input  logic [arcr_pkg::CFG_W-1:0]    i_cfg_data
);
    import arcr_pkg::*;

    localparam int DEPTH = 2 * CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int PW    = $clog2(CAPACITY + 1);
    localparam int SW    = LW + 2;

    typedef struct packed {
        logic             v;
        logic [KEY_W-1:0] key;
        t_list            lst;
        logic [AW-1:0]    rank;
    } t_entry;

    typedef struct packed {
        t_op_kind      kind;
        logic [AW-1:0] idx;
        t_list         src;
        logic [AW-1:0] rank;
        t_list         dst;
    } t_op;

    localparam t_op OP_EMPTY = '{kind: OP_NONE, idx: '0, src: LIST_T1, rank: '0, dst: LIST_T1};

    // state and sweep control
    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt;
    logic          r_run;
    logic          r_pv;
    logic [AW-1:0] r_pidx;

    // directory memory
    t_entry        mem [DEPTH];
    t_entry        r_q;
    logic          w_we;
    logic [AW-1:0] w_wa;
    t_entry        w_wd;

    // request and lookup results
    logic [KEY_W-1:0] r_key;
    logic             r_hit_f;
    logic [AW-1:0]    r_hit_idx;
    t_list            r_hit_lst;
    logic [AW-1:0]    r_hit_rank;
    logic             r_free_f;
    logic [AW-1:0]    r_free_idx;
    logic             r_lru_f   [4];
    logic [AW-1:0]    r_lru_idx [4];

    // directory summary
    logic [LW-1:0]    r_len [4];
    logic [LW-1:0]    w_len_nx [4];
    logic [PW-1:0]    r_p;
    logic [HIT_W-1:0] r_hits;
    logic [CFG_W-1:0] r_cfg;
    logic [PW-1:0]    w_c;

    // planned list edits
    t_op        r_ops [3];
    t_op        w_ops [3];
    logic [1:0] r_nops;
    logic [1:0] r_op_sel;
    logic [1:0] w_k;
    t_op        w_cur;
    t_op        w_rep;
    logic       w_rep_t1;
    logic       w_inb2;
    logic       w_drop_f;
    logic [AW-1:0] w_drop_idx;
    t_outcome   w_outc;
    t_outcome   r_outc;
    logic       w_hit_inc;
    logic [SW-1:0] w_l1, w_l2, w_cs;
    t_entry     w_edit_wd;

    // result register
    logic             r_ov;
    t_outcome         r_o_outc;
    logic [HIT_W-1:0] r_o_hit;

    // divider
    logic          w_div_start;
    logic          w_div_done;
    logic [LW-1:0] w_div_num, w_div_den, w_quo, w_delta;
    logic [LW:0]   w_psum;

    logic w_pass_end;
    logic w_ghost;
    logic w_sweep_start;
    logic w_out_load;

    assign w_pass_end = r_pv && (r_pidx == AW'(DEPTH - 1));
    assign w_ghost    = r_hit_f && (r_hit_lst == LIST_B1 || r_hit_lst == LIST_B2);
    assign w_cur      = r_ops[r_op_sel];

    // Clamp cache size into 1..CAPACITY
    always_comb begin
        if (r_cfg == '0) begin
            w_c = PW'(1);
        end else if (32'(r_cfg) > 32'(CAPACITY)) begin
            w_c = PW'(CAPACITY);
        end else begin
            w_c = PW'(r_cfg);
        end
    end

    // Directory memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_q <= mem[r_cnt];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_cnt == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_LOOK;
            S_LOOK:  if (w_pass_end) n_state = S_ADAPT;
            S_ADAPT: n_state = w_ghost ? S_DIV : S_PLAN;
            S_DIV:   if (w_div_done) n_state = S_PLAN;
            S_PLAN:  n_state = (w_k != 2'd0) ? S_EDIT : S_DONE;
            S_EDIT:  if (w_pass_end && r_op_sel == 2'(r_nops - 2'd1)) n_state = S_DONE;
            S_DONE:  if (!r_ov || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        w_sweep_start = ((r_state == S_IDLE) && i_in_valid) ||
                        ((r_state == S_PLAN) && (w_k != 2'd0)) ||
                        ((r_state == S_EDIT) && w_pass_end &&
                         (r_op_sel != 2'(r_nops - 2'd1)));
        w_div_start   = (r_state == S_ADAPT) && w_ghost;
        w_out_load    = (r_state == S_DONE) && (!r_ov || !i_out_stall);
        w_we          = 1'b0;
        w_wa          = r_pidx;
        w_wd          = w_edit_wd;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = r_cnt;
                w_wd = '0;
            end
            S_EDIT:  w_we = r_pv;
            default: w_we = 1'b0;
        endcase
    end

    // Edit of one entry during an edit sweep
    always_comb begin
        w_edit_wd = r_q;
        if (r_pidx == w_cur.idx) begin
            case (w_cur.kind)
                OP_DROP: w_edit_wd.v = 1'b0;
                OP_MOVE: begin
                    w_edit_wd.lst  = w_cur.dst;
                    w_edit_wd.rank = '0;
                end
                OP_INSERT: begin
                    w_edit_wd.v    = 1'b1;
                    w_edit_wd.key  = r_key;
                    w_edit_wd.lst  = LIST_T1;
                    w_edit_wd.rank = '0;
                end
                default: w_edit_wd = r_q;
            endcase
        end else if (r_q.v) begin
            // close the gap behind the removed entry, then open rank 0
            if ((w_cur.kind == OP_DROP || w_cur.kind == OP_MOVE) &&
                r_q.lst == w_cur.src && r_q.rank > w_cur.rank) begin
                w_edit_wd.rank = w_edit_wd.rank - AW'(1);
            end
            if ((w_cur.kind == OP_MOVE || w_cur.kind == OP_INSERT) &&
                r_q.lst == w_cur.dst) begin
                w_edit_wd.rank = w_edit_wd.rank + AW'(1);
            end
        end
    end

    // List lengths after the current edit
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_len_nx[l] = r_len[l];
        end
        if ((w_cur.kind == OP_DROP || w_cur.kind == OP_MOVE) && w_len_nx[w_cur.src] != '0) begin
            w_len_nx[w_cur.src] = w_len_nx[w_cur.src] - LW'(1);
        end
        if (w_cur.kind == OP_MOVE || w_cur.kind == OP_INSERT) begin
            w_len_nx[w_cur.dst] = w_len_nx[w_cur.dst] + LW'(1);
        end
    end

    // Replace step: demote LRU of T1 to B1, or LRU of T2 to B2
    assign w_inb2   = r_hit_f && (r_hit_lst == LIST_B2);
    assign w_rep_t1 = (r_len[LIST_T1] != '0) &&
                      ((w_inb2 && r_len[LIST_T1] == LW'(r_p)) || r_len[LIST_T1] > LW'(r_p));

    always_comb begin
        if (w_rep_t1) begin
            w_rep = '{kind: r_lru_f[LIST_T1] ? OP_MOVE : OP_NONE, idx: r_lru_idx[LIST_T1],
                      src: LIST_T1, rank: AW'(r_len[LIST_T1] - LW'(1)), dst: LIST_B1};
        end else begin
            w_rep = '{kind: r_lru_f[LIST_T2] ? OP_MOVE : OP_NONE, idx: r_lru_idx[LIST_T2],
                      src: LIST_T2, rank: AW'(r_len[LIST_T2] - LW'(1)), dst: LIST_B2};
        end
    end

    assign w_l1 = SW'(r_len[LIST_T1]) + SW'(r_len[LIST_B1]);
    assign w_l2 = SW'(r_len[LIST_T2]) + SW'(r_len[LIST_B2]);
    assign w_cs = SW'(w_c);

    // Plan the list edits of this request
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ops[i] = OP_EMPTY;
        end
        w_k        = 2'd0;
        w_drop_f   = 1'b0;
        w_drop_idx = '0;
        w_outc     = OUT_MISS;
        w_hit_inc  = 1'b0;
        if (!r_hit_f) begin
            if (w_l1 == w_cs) begin
                if (SW'(r_len[LIST_T1]) < w_cs) begin
                    if (r_lru_f[LIST_B1]) begin
                        w_ops[w_k] = '{kind: OP_DROP, idx: r_lru_idx[LIST_B1], src: LIST_B1,
                                       rank: AW'(r_len[LIST_B1] - LW'(1)), dst: LIST_B1};
                        w_drop_f   = 1'b1;
                        w_drop_idx = r_lru_idx[LIST_B1];
                        w_k        = w_k + 2'd1;
                    end
                    if (w_rep.kind != OP_NONE) begin
                        w_ops[w_k] = w_rep;
                        w_k        = w_k + 2'd1;
                    end
                end else if (r_lru_f[LIST_T1]) begin
                    // T1 alone fills the cache: drop its LRU page outright
                    w_ops[w_k] = '{kind: OP_DROP, idx: r_lru_idx[LIST_T1], src: LIST_T1,
                                   rank: AW'(r_len[LIST_T1] - LW'(1)), dst: LIST_T1};
                    w_drop_f   = 1'b1;
                    w_drop_idx = r_lru_idx[LIST_T1];
                    w_k        = w_k + 2'd1;
                end
            end else if (w_l1 < w_cs && SW'(w_l1 + w_l2) >= w_cs) begin
                if (SW'(w_l1 + w_l2) >= SW'({w_c, 1'b0}) && r_lru_f[LIST_B2]) begin
                    w_ops[w_k] = '{kind: OP_DROP, idx: r_lru_idx[LIST_B2], src: LIST_B2,
                                   rank: AW'(r_len[LIST_B2] - LW'(1)), dst: LIST_B2};
                    w_drop_f   = 1'b1;
                    w_drop_idx = r_lru_idx[LIST_B2];
                    w_k        = w_k + 2'd1;
                end
                if (w_rep.kind != OP_NONE) begin
                    w_ops[w_k] = w_rep;
                    w_k        = w_k + 2'd1;
                end
            end
            // lowest free entry once the evictions are done
            if (r_free_f && !(w_drop_f && w_drop_idx < r_free_idx)) begin
                w_ops[w_k] = '{kind: OP_INSERT, idx: r_free_idx, src: LIST_T1,
                               rank: '0, dst: LIST_T1};
                w_k        = w_k + 2'd1;
            end else if (w_drop_f) begin
                w_ops[w_k] = '{kind: OP_INSERT, idx: w_drop_idx, src: LIST_T1,
                               rank: '0, dst: LIST_T1};
                w_k        = w_k + 2'd1;
            end
        end else begin
            case (r_hit_lst)
                LIST_B1, LIST_B2: begin
                    w_outc = (r_hit_lst == LIST_B1) ? OUT_GHOST_B1 : OUT_GHOST_B2;
                    if (w_rep.kind != OP_NONE) begin
                        w_ops[w_k] = w_rep;
                        w_k        = w_k + 2'd1;
                    end
                    // the demotion may push the ghost entry one place back
                    w_ops[w_k] = '{kind: OP_MOVE, idx: r_hit_idx, src: r_hit_lst,
                                   rank: r_hit_rank + AW'((w_rep.kind != OP_NONE) &&
                                                          (w_rep.dst == r_hit_lst)),
                                   dst: LIST_T2};
                    w_k        = w_k + 2'd1;
                end
                default: begin
                    w_outc     = OUT_HIT;
                    w_hit_inc  = 1'b1;
                    w_ops[w_k] = '{kind: OP_MOVE, idx: r_hit_idx, src: r_hit_lst,
                                   rank: r_hit_rank, dst: LIST_T2};
                    w_k        = w_k + 2'd1;
                end
            endcase
        end
    end

    // Target adaptation from the ghost list ratio
    assign w_div_num = (r_hit_lst == LIST_B1) ? r_len[LIST_B2] : r_len[LIST_B1];
    assign w_div_den = (r_hit_lst == LIST_B1) ? r_len[LIST_B1] : r_len[LIST_B2];
    assign w_delta   = (w_quo == '0) ? LW'(1) : w_quo;
    assign w_psum    = (LW + 1)'(r_p) + (LW + 1)'(w_delta);

    arcr_div #(
        .W (LW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_run    <= 1'b0;
            r_pv     <= 1'b0;
            r_cfg    <= CFG_RESET;
            r_p      <= '0;
            r_hits   <= '0;
            r_ov     <= 1'b0;
            r_nops   <= 2'd0;
            r_op_sel <= 2'd0;
            r_hit_f  <= 1'b0;
            r_free_f <= 1'b0;
            for (int l = 0; l < 4; l++) begin
                r_len[l]   <= '0;
                r_lru_f[l] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end

            // sweep address: advance one entry a cycle
            if (r_state == S_CLEAR) begin
                r_cnt <= (r_cnt == AW'(DEPTH - 1)) ? '0 : r_cnt + AW'(1);
            end else if (w_sweep_start) begin
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_cnt == AW'(DEPTH - 1)) begin
                    r_run <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + AW'(1);
                end
            end
            r_pv   <= r_run;
            r_pidx <= r_cnt;

            if (r_state == S_IDLE && i_in_valid) begin
                r_key    <= i_page_key;
                r_hit_f  <= 1'b0;
                r_free_f <= 1'b0;
                for (int l = 0; l < 4; l++) begin
                    r_lru_f[l] <= 1'b0;
                end
            end

            // lookup: first match, first free slot, LRU of each list
            if (r_state == S_LOOK && r_pv) begin
                if (r_q.v && r_q.key == r_key && !r_hit_f) begin
                    r_hit_f    <= 1'b1;
                    r_hit_idx  <= r_pidx;
                    r_hit_lst  <= r_q.lst;
                    r_hit_rank <= r_q.rank;
                end
                if (!r_q.v && !r_free_f) begin
                    r_free_f   <= 1'b1;
                    r_free_idx <= r_pidx;
                end
                for (int l = 0; l < 4; l++) begin
                    if (r_q.v && r_q.lst == t_list'(2'(l)) && r_len[l] != '0 &&
                        LW'(r_q.rank) == r_len[l] - LW'(1) && !r_lru_f[l]) begin
                        r_lru_f[l]   <= 1'b1;
                        r_lru_idx[l] <= r_pidx;
                    end
                end
            end

            if (r_state == S_DIV && w_div_done) begin
                if (r_hit_lst == LIST_B1) begin
                    r_p <= (w_psum > (LW + 1)'(w_c)) ? w_c : PW'(w_psum);
                end else begin
                    r_p <= (LW'(r_p) > w_delta) ? PW'(LW'(r_p) - w_delta) : '0;
                end
            end

            if (r_state == S_PLAN) begin
                r_ops    <= w_ops;
                r_nops   <= w_k;
                r_op_sel <= 2'd0;
                r_outc   <= w_outc;
                if (w_hit_inc) begin
                    r_hits <= r_hits + HIT_W'(1);
                end
            end

            // end of an edit sweep: commit lengths, go to the next edit
            if (r_state == S_EDIT && w_pass_end) begin
                r_len    <= w_len_nx;
                r_op_sel <= r_op_sel + 2'd1;
            end

            // result register: hold until taken
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_outc <= r_outc;
            r_o_hit  <= r_hits;
        end
    end

    assign o_out_valid = r_ov;
    assign o_outcome   = r_o_outc;
    assign o_hit_total = r_o_hit;

endmodule

// ===== rtl/arcr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcr_div
// Restoring unsigned divider, one quotient bit per cycle; divisor 0 acts as 1.
// ----------------------------------------------------------------------------
module arcr_div #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= (i_den == '0) ? W'(1) : i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? W'(w_trial - {1'b0, r_den}) : W'(w_trial);
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== dv/arc_directory_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_directory_checker
// Watches the request and result channels of the ARC directory, predicts the
// outcome and hit count of each request and compares them with the block.
// ----------------------------------------------------------------------------
module arc_directory_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [arcr_pkg::KEY_W-1:0] i_page_key,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [arcr_pkg::OUT_W-1:0] i_outcome,
    input  logic [arcr_pkg::HIT_W-1:0] i_hit_total,
    input  logic                       i_cfg_we,
    input  logic [arcr_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_requests,
    output int                         o_results,
    output int                         o_ghost_hits
);
    import arcr_pkg::*;

    localparam int DEPTH = 2 * CAPACITY;

    typedef struct packed {
        t_outcome          outcome;
        logic [HIT_W-1:0]  hits;
    } t_answer;

    logic [KEY_W-1:0] dir_key   [DEPTH];
    logic             dir_used  [DEPTH];
    t_list            dir_list  [DEPTH];
    int               dir_pos   [DEPTH];
    int               len       [4];
    int               p_target;
    logic [HIT_W-1:0] hit_count;
    logic [CFG_W-1:0] size_reg;
    t_answer          answers[$];

    task automatic unlink(int e);
        for (int i = 0; i < DEPTH; i++)
            if (i != e && dir_used[i] && dir_list[i] == dir_list[e] && dir_pos[i] > dir_pos[e])
                dir_pos[i]--;
        if (len[dir_list[e]] > 0) len[dir_list[e]]--;
    endtask

    task automatic push_mru(int e, t_list l);
        for (int i = 0; i < DEPTH; i++)
            if (i != e && dir_used[i] && dir_list[i] == l) dir_pos[i]++;
        dir_list[e] = l;
        dir_pos[e]  = 0;
        len[l]++;
    endtask

    function automatic int find_lru(t_list l);
        if (len[l] == 0) return -1;
        for (int i = 0; i < DEPTH; i++)
            if (dir_used[i] && dir_list[i] == l && dir_pos[i] == len[l] - 1) return i;
        return -1;
    endfunction

    task automatic evict(t_list l);
        int e;
        e = find_lru(l);
        if (e < 0) return;
        unlink(e);
        dir_used[e] = 1'b0;
    endtask

    task automatic demote(t_list from, t_list to);
        int e;
        e = find_lru(from);
        if (e < 0) return;
        unlink(e);
        push_mru(e, to);
    endtask

    task automatic make_room(bit from_b2);
        if (len[LIST_T1] >= 1 && ((from_b2 && len[LIST_T1] == p_target) || len[LIST_T1] > p_target))
            demote(LIST_T1, LIST_B1);
        else
            demote(LIST_T2, LIST_B2);
    endtask

    // Work out one request and queue its answer.
    task automatic serve_page(logic [KEY_W-1:0] key);
        int c, hit, l1, l2, d;
        t_outcome oc;
        c = (size_reg < 1) ? 1 : (size_reg > CAPACITY) ? CAPACITY : int'(size_reg);
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && dir_used[i] && dir_key[i] == key) hit = i;
        if (hit < 0) begin
            l1 = len[LIST_T1] + len[LIST_B1];
            l2 = len[LIST_T2] + len[LIST_B2];
            if (l1 == c) begin
                if (len[LIST_T1] < c) begin
                    evict(LIST_B1);
                    make_room(1'b0);
                end else begin
                    evict(LIST_T1);
                end
            end else if (l1 < c && l1 + l2 >= c) begin
                if (l1 + l2 >= 2 * c) evict(LIST_B2);
                make_room(1'b0);
            end
            for (int i = 0; i < DEPTH; i++)
                if (!dir_used[i]) begin
                    dir_used[i] = 1'b1;
                    dir_key[i]  = key;
                    push_mru(i, LIST_T1);
                    break;
                end
            oc = OUT_MISS;
        end else begin
            if (dir_list[hit] == LIST_T1 || dir_list[hit] == LIST_T2) begin
                hit_count++;
                oc = OUT_HIT;
            end else if (dir_list[hit] == LIST_B1) begin
                d = len[LIST_B2] / (len[LIST_B1] == 0 ? 1 : len[LIST_B1]);
                if (d < 1) d = 1;
                p_target = (p_target + d > c) ? c : p_target + d;
                make_room(1'b0);
                oc = OUT_GHOST_B1;
            end else begin
                d = len[LIST_B1] / (len[LIST_B2] == 0 ? 1 : len[LIST_B2]);
                if (d < 1) d = 1;
                p_target = (p_target > d) ? p_target - d : 0;
                make_room(1'b1);
                oc = OUT_GHOST_B2;
            end
            unlink(hit);
            push_mru(hit, LIST_T2);
        end
        if (oc inside {OUT_GHOST_B1, OUT_GHOST_B2}) o_ghost_hits++;
        answers.push_back('{outcome: oc, hits: hit_count});
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("checker: result %0d %s got %0h want %0h", o_results, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                dir_used[i] = 1'b0;
                dir_key[i]  = '0;
                dir_list[i] = LIST_T1;
                dir_pos[i]  = 0;
            end
            for (int i = 0; i < 4; i++) len[i] = 0;
            p_target  = 0;
            hit_count = '0;
            size_reg  = CFG_RESET;
            answers.delete();
            o_errors = 0; o_requests = 0; o_results = 0; o_ghost_hits = 0;
        end else begin
            if (i_cfg_we) size_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                serve_page(i_page_key);
                o_requests++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (answers.size() == 0) begin
                    report_mismatch("with no request waiting", 64'(i_outcome), '0);
                end else begin
                    a = answers.pop_front();
                    if (i_outcome != a.outcome)
                        report_mismatch("outcome", 64'(i_outcome), 64'(a.outcome));
                    if (i_hit_total != a.hits)
                        report_mismatch("hit_total", 64'(i_hit_total), 64'(a.hits));
                end
                o_results++;
            end
        end
        o_pending = answers.size();
    end

endmodule

// ===== dv/tb_arc_cache_replacement_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arc_cache_replacement_core
// Drives page requests and cache size changes into the ARC directory under
// random idling on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_arc_cache_replacement_core;
    import arcr_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int LIMIT     = 20000;   // idle cycles before giving up
    localparam int SETTLE    = 1200;    // settle wait after the last result

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [KEY_W-1:0] i_page_key = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [OUT_W-1:0] o_outcome;
    logic [HIT_W-1:0] o_hit_total;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    int errors, pending, requests, results, ghost_hits;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    arc_cache_replacement_core #(.CAPACITY(CAPACITY)) uut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_page_key,
        .o_out_valid, .i_out_stall, .o_outcome, .o_hit_total,
        .i_cfg_we, .i_cfg_data
    );

    arc_directory_checker #(.CAPACITY(CAPACITY)) u_check (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_page_key,
        .i_out_valid(o_out_valid), .i_out_stall, .i_outcome(o_outcome),
        .i_hit_total(o_hit_total), .i_cfg_we, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_requests(requests),
        .o_results(results), .o_ghost_hits(ghost_hits)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: stall at random on each falling edge.
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Watchdog: count cycles in which neither channel moves.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one request and hold it until taken, idling beforehand at random.
    // Valid drops only while idling or draining, so back-to-back requests
    // never see two drives of it in one step.
    task automatic send_request(logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_key <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off until every result is back, then let the block settle.
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_size(logic [CFG_W-1:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Pick a key: mostly from a small working set so hits and ghost hits occur.
    function automatic logic [KEY_W-1:0] pick_key(int span);
        logic [KEY_W-1:0] k;
        if ($urandom_range(99) < 85) k = KEY_W'($urandom_range(span - 1));
        else k = KEY_W'($urandom());
        return k;
    endfunction

    task automatic random_phase(int count, int span);
        for (int n = 0; n < count; n++) send_request(pick_key(span));
    endtask

    initial begin
        logic [CFG_W-1:0] sizes[6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd20};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key extremes, repeats for hits, and a tiny cache for ghosts.
        send_request('0);
        send_request({KEY_W{1'b1}});
        send_request('0);
        send_request({KEY_W{1'b1}});
        send_request(31'h2AAA_AAAA);
        send_request(31'h5555_5555);
        set_size(7'd2);
        for (int k = 1; k <= 6; k++) send_request(KEY_W'(k));
        send_request(31'd1); send_request(31'd2); send_request(31'd5);
        send_request(31'd6); send_request(31'd5); send_request(31'd3);
        // Shrink below the lists already held, then overflow.
        set_size(7'd1);
        send_request(31'd7); send_request(31'd8); send_request(31'd7); send_request(31'd2);

        // Random phases over several sizes and idling patterns.
        for (int ph = 0; ph < 6; ph++) begin
            set_size(sizes[ph]);
            case (ph % 3)
                0: begin send_idle_pct = 23; recv_idle_pct = 88; end
                1: begin send_idle_pct = 88; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            random_phase(155, (sizes[ph] < 2) ? 4 : 2 * int'(sizes[ph]) + 4);
        end

        drain();
        $display("tb: %0d requests, %0d results, %0d ghost hits, cache sizes 0 to 127",
                 requests, results, ghost_hits);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
